>>> rtl/assert_macros.svh
// Assertion macros used by the checker file pkcs7_chk.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is asserted (active low).
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Clocked property that also holds across reset.
`define ASSERT_CLK_NORST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

>>> rtl/pkcs7_pkg.sv
// Shared constants, status codes and controller/datapath interface structs
// for the PKCS#7 unpad checker. No dependencies.
package pkcs7_pkg;

    localparam int MAX_BLOCK_DEF = 32;
    localparam int CFG_W         = 6;
    localparam logic [CFG_W-1:0] BS_RESET = 6'd16;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_LEN = 2'd1;
    localparam logic [1:0] ST_PAD = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic take;        // input ready
        logic rd;          // read held byte at index
        logic chk;         // compare read byte with pad value
        logic ld_data;     // load output register with read byte
        logic start_emit;  // restart index for trailing data emission
        logic ld_stat;     // load output register with closing status word
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_valid;
        logic in_last;
        logic full;        // incoming byte completes a block
        logic len_ok;      // count equals block size
        logic pad_ok;      // 1 <= pad <= block size
        logic at_end;      // index is on the last element of the range
        logic emit_none;   // block is all padding
        logic code_bad;    // status code not ok
        logic out_free;    // output register free at next edge
    } t_sts;

endpackage

>>> rtl/pkcs7_dpath.sv
// Datapath: block buffer memory, counters, pad check and output register.
// Depends on pkcs7_pkg.
module pkcs7_dpath
    import pkcs7_pkg::*;
#(
    parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    input  logic [7:0]       i_in_data,
    input  logic             i_in_last,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [7:0]       o_out_byte,
    output logic             o_out_byte_valid,
    output logic             o_out_eom,
    output logic [1:0]       o_out_status
);

    localparam int AW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam int CW = $clog2(MAX_BLOCK + 1);
    localparam int EW = (CW > CFG_W) ? CW : CFG_W;
    localparam int PW = (CW > 8) ? CW : 8;

    logic [7:0]       r_mem [MAX_BLOCK];
    logic [7:0]       r_rdata;
    logic [CFG_W-1:0] r_bs;
    logic [AW-1:0]    r_fill;
    logic [CW-1:0]    r_n;
    logic [7:0]       r_pad;
    logic [CW-1:0]    r_idx;
    logic [CW-1:0]    r_end;
    logic [1:0]       r_code;
    logic             r_ov;
    logic [7:0]       r_ob;
    logic             r_ovf;
    logic             r_oeom;
    logic [1:0]       r_ost;

    logic [EW-1:0] bs_ext;
    logic [EW-1:0] eff_ext;
    logic [CW-1:0] eff;
    logic [CW-1:0] n_cnt;
    logic          take;
    logic          full;
    logic          len_ok;
    logic          pad_ok;
    logic [CW-1:0] idx_inc;

    // effective block size: zero acts as one, clamp to buffer depth
    always_comb begin
        bs_ext = EW'(r_bs);
        if (r_bs == '0) begin
            eff_ext = EW'(1);
        end else if (bs_ext > EW'(MAX_BLOCK)) begin
            eff_ext = EW'(MAX_BLOCK);
        end else begin
            eff_ext = bs_ext;
        end
        eff = eff_ext[CW-1:0];
    end

    assign n_cnt   = CW'(r_fill) + CW'(1);
    assign take    = i_cmd.take & i_in_valid;
    assign full    = (n_cnt >= eff);
    assign len_ok  = (n_cnt == eff);
    assign pad_ok  = (i_in_data != 8'd0) && (PW'(i_in_data) <= PW'(eff));
    assign idx_inc = r_idx + CW'(1);

    always_comb begin
        o_sts.in_valid  = i_in_valid;
        o_sts.in_last   = i_in_last;
        o_sts.full      = full;
        o_sts.len_ok    = len_ok;
        o_sts.pad_ok    = pad_ok;
        o_sts.at_end    = (idx_inc == r_end);
        o_sts.emit_none = (r_n == CW'(r_pad));
        o_sts.code_bad  = (r_code != ST_OK);
        o_sts.out_free  = !r_ov || i_out_ready;
    end

    // block buffer
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_mem[r_fill] <= i_in_data;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bs   <= BS_RESET;
            r_fill <= '0;
        end else begin
            if (i_cfg_we) begin
                r_bs <= i_cfg_wdata;
            end
            if (take) begin
                r_fill <= (!i_in_last && !full) ? n_cnt[AW-1:0] : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_n   <= n_cnt;
            r_pad <= i_in_data;
            r_end <= n_cnt;
            r_idx <= i_in_last ? (n_cnt - CW'(i_in_data)) : '0;
            if (!len_ok) begin
                r_code <= ST_LEN;
            end else if (!pad_ok) begin
                r_code <= ST_PAD;
            end else begin
                r_code <= ST_OK;
            end
        end else if (i_cmd.start_emit) begin
            r_idx <= '0;
            r_end <= r_n - CW'(r_pad);
        end else if (i_cmd.chk) begin
            r_idx <= idx_inc;
            if (r_rdata != r_pad) begin
                r_code <= ST_PAD;
            end
        end else if (i_cmd.ld_data) begin
            r_idx <= idx_inc;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.ld_data || i_cmd.ld_stat) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_data) begin
            r_ob   <= r_rdata;
            r_ovf  <= 1'b1;
            r_oeom <= 1'b0;
            r_ost  <= ST_OK;
        end else if (i_cmd.ld_stat) begin
            r_ob   <= 8'd0;
            r_ovf  <= 1'b0;
            r_oeom <= 1'b1;
            r_ost  <= r_code;
        end
    end

    assign o_out_valid      = r_ov;
    assign o_out_byte       = r_ob;
    assign o_out_byte_valid = r_ovf;
    assign o_out_eom        = r_oeom;
    assign o_out_status     = r_ost;

endmodule

>>> rtl/pkcs7_ctrl.sv
// Controller FSM: input acceptance, pad byte check, emission and status.
// Depends on pkcs7_pkg.
module pkcs7_ctrl
    import pkcs7_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK_RD,
        S_CHK_CMP,
        S_CHK_DONE,
        S_EMIT_RD,
        S_EMIT_LD,
        S_STAT
    } t_state;

    t_state r_state, n_state;
    logic   r_final, n_final;

    always_comb begin
        n_state = r_state;
        n_final = r_final;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.take = 1'b1;
                if (i_sts.in_valid) begin
                    if (!i_sts.in_last) begin
                        if (i_sts.full) begin
                            n_final = 1'b0;
                            n_state = S_EMIT_RD;
                        end
                    end else begin
                        n_final = 1'b1;
                        n_state = (i_sts.len_ok && i_sts.pad_ok) ? S_CHK_RD : S_STAT;
                    end
                end
            end
            S_CHK_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_CHK_CMP;
            end
            S_CHK_CMP: begin
                o_cmd.chk = 1'b1;
                n_state   = i_sts.at_end ? S_CHK_DONE : S_CHK_RD;
            end
            S_CHK_DONE: begin
                if (i_sts.code_bad || i_sts.emit_none) begin
                    n_state = S_STAT;
                end else begin
                    o_cmd.start_emit = 1'b1;
                    n_state          = S_EMIT_RD;
                end
            end
            S_EMIT_RD: begin
                // only read once the output register is sure to be empty
                if (i_sts.out_free) begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_EMIT_LD;
                end
            end
            S_EMIT_LD: begin
                o_cmd.ld_data = 1'b1;
                if (i_sts.at_end) begin
                    n_state = r_final ? S_STAT : S_IDLE;
                end else begin
                    n_state = S_EMIT_RD;
                end
            end
            S_STAT: begin
                if (i_sts.out_free) begin
                    o_cmd.ld_stat = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            r_final <= n_final;
        end
    end

endmodule

>>> rtl/pkcs7_unpad_checker.sv
// Channel     | Dir | tdata (low bit up)                | tlast          | tuser
// s_axis      | in  | [7:0] data_byte                   | is_last        | -
// m_axis      | out | [7:0] out_byte, [9:8] status, 0s  | end_of_message | [0] byte_valid
// cfg         | in  | i_cfg_wdata = blk_len (6 bits)    | -              | -
//
// Bytes are taken one per cycle while no block is being emitted or checked.
// A completed block of n bytes is re-emitted, each word by a buffer read
// then an output load. A final byte with good length and pad value has each
// pad byte read and compared, a decision, kept bytes if valid, then status.
// Synchronous active-low reset clears the fill count and output valid, sets
// blk_len to 16. Output stalls hold the emission; input ready is low meanwhile.
// Top level of the PKCS#7 unpad checker: controller FSM plus datapath.
// Depends on pkcs7_pkg, pkcs7_ctrl and pkcs7_dpath.
module pkcs7_unpad_checker
    import pkcs7_pkg::*;
#(
    parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,       // [5:0] blk_len
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [7:0]       i_s_axis_tdata,    // [7:0] data_byte
    input  logic             i_s_axis_tlast,
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata,    // [7:0] out_byte, [9:8] status
    output logic             o_m_axis_tlast,
    output logic [0:0]       o_m_axis_tuser     // [0] byte_valid
);

    t_cmd       cmd;
    t_sts       sts;
    logic [7:0] out_byte;
    logic [1:0] out_status;
    logic       out_bv;

    pkcs7_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    pkcs7_dpath #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_s_axis_tvalid),
        .i_in_data        (i_s_axis_tdata),
        .i_in_last        (i_s_axis_tlast),
        .i_out_ready      (i_m_axis_tready),
        .o_out_valid      (o_m_axis_tvalid),
        .o_out_byte       (out_byte),
        .o_out_byte_valid (out_bv),
        .o_out_eom        (o_m_axis_tlast),
        .o_out_status     (out_status)
    );

    assign o_s_axis_tready   = cmd.take;
    assign o_m_axis_tdata    = {6'd0, out_status, out_byte};
    assign o_m_axis_tuser[0] = out_bv;

endmodule

>>> rtl/pkcs7_chk.sv
// Port-level checker for pkcs7_unpad_checker, bound to the top level.
// Depends on assert_macros.svh and pkcs7_pkg.
`include "assert_macros.svh"

module pkcs7_chk
    import pkcs7_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic [15:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast,
    input logic [0:0]  o_m_axis_tuser
);

    logic [7:0] out_byte;
    logic [1:0] out_st;
    logic       out_bv;
    logic       is_stat;
    logic       st_known;

    assign out_byte = o_m_axis_tdata[7:0];
    assign out_st   = o_m_axis_tdata[9:8];
    assign out_bv   = o_m_axis_tuser[0];
    assign is_stat  = o_m_axis_tvalid && o_m_axis_tlast;
    assign st_known = (out_st == ST_OK) || (out_st == ST_LEN) || (out_st == ST_PAD);

    // every word is either a data byte or the closing status word
    `ASSERT_CLK(a_kind, i_clk, i_rst_n, o_m_axis_tvalid |-> (out_bv != o_m_axis_tlast))
    // data words carry an ok status
    `ASSERT_CLK(a_data_st, i_clk, i_rst_n, (o_m_axis_tvalid && out_bv) |-> (out_st == ST_OK))
    // status words carry a zero byte and a defined code
    `ASSERT_CLK(a_stat, i_clk, i_rst_n, is_stat |-> ((out_byte == 8'd0) && st_known))
    // output is empty right after reset
    `ASSERT_CLK_NORST(a_rst, i_clk, !i_rst_n |=> !o_m_axis_tvalid)

endmodule

bind pkcs7_unpad_checker pkcs7_chk u_pkcs7_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
